/* src/sqpt_pkg.sv */
// Package with the shared types, codes and helper function of the send-queue tracker.
`timescale 1ns / 1ps

package sqpt_pkg;

	// Field widths of the channels and registers.
	localparam int LEN_W   = 31;
	localparam int SLOT_W  = 16;
	localparam int PSN_W   = 24;
	localparam int MTU_W   = 14;
	localparam int STAT_W  = 2;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;

	// Shared divider sizing: the widest dividend is the message length.
	localparam int DIV_W   = 31;
	localparam int CNT_W   = 5;

	// Reset values of the configuration registers.
	localparam logic [SLOT_W-1:0] DEPTH_RESET = 16'd256;
	localparam logic [MTU_W-1:0]  MTU_RESET   = 14'd1024;
	localparam logic [SLOT_W-1:0] TSIZE_RESET = 16'd64;
	localparam logic [SLOT_W-1:0] ILIM_RESET  = 16'd0;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_QUEUE_DEPTH    = 2'd0;
	localparam logic [CIDX_W-1:0] REG_PATH_MTU       = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MSG_TABLE_SIZE = 2'd2;
	localparam logic [CIDX_W-1:0] REG_INLINE_LIMIT   = 2'd3;

	// Opcodes of an input transaction.
	localparam logic OP_POST     = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	// Status codes of a result transaction.
	localparam logic [STAT_W-1:0] STAT_POSTED   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_REFUSED  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_COMPLETE = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HEAD_MOD,
		ST_TAIL_MOD,
		ST_CHECK,
		ST_LEN_DIV,
		ST_PTR_MOD,
		ST_TAIL_ADV,
		ST_FINISH,
		ST_EMIT
	} state_t;

	// Request to the shared divider.
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [SLOT_W-1:0] divisor;
		logic [CNT_W-1:0] nbits;
	} div_req_t;

	// Response from the shared divider.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_W-1:0]  quotient;
		logic [SLOT_W-1:0] remainder;
	} div_rsp_t;

	// One result transaction.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] wqe_start_slot;
		logic [SLOT_W-1:0] doorbell_slot;
		logic              epoch_bit;
		logic [SLOT_W-1:0] msg_entry_index;
		logic [PSN_W-1:0]  first_psn;
		logic [PSN_W-1:0]  end_psn;
		logic              inline_payload;
		logic [SLOT_W-1:0] head_slot;
		logic [SLOT_W-1:0] free_slots;
	} result_t;

	// Free slots from tail and head already reduced below the depth.
	function automatic logic [SLOT_W-1:0] sqpt_free(input logic [SLOT_W-1:0] tm,
			input logic [SLOT_W-1:0] hm, input logic [SLOT_W-1:0] d);
		logic [SLOT_W:0]   s;
		logic [SLOT_W-1:0] occ;
		s = {1'b0, tm} + {1'b0, d} - {1'b0, hm};
		if (s >= {1'b0, d}) begin
			occ = SLOT_W'(s - {1'b0, d});
		end else begin
			occ = s[SLOT_W-1:0];
		end
		return d - occ;
	endfunction

endpackage

/* src/sqpt_if.sv */
// Channel interfaces for request and result transactions of the send-queue tracker.
`timescale 1ns / 1ps

interface sqpt_req_if
	import sqpt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [LEN_W-1:0]  msg_length;
	logic              is_rdma_write;
	logic [SLOT_W-1:0] consumer_index;

	modport source(output valid, output opcode, output msg_length, output is_rdma_write,
		output consumer_index, input ready);
	modport sink(input valid, input opcode, input msg_length, input is_rdma_write,
		input consumer_index, output ready);
endinterface

interface sqpt_rsp_if
	import sqpt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] wqe_start_slot;
	logic [SLOT_W-1:0] doorbell_slot;
	logic              epoch_bit;
	logic [SLOT_W-1:0] msg_entry_index;
	logic [PSN_W-1:0]  first_psn;
	logic [PSN_W-1:0]  end_psn;
	logic              inline_payload;
	logic [SLOT_W-1:0] head_slot;
	logic [SLOT_W-1:0] free_slots;

	modport source(output valid, output status, output wqe_start_slot, output doorbell_slot,
		output epoch_bit, output msg_entry_index, output first_psn, output end_psn,
		output inline_payload, output head_slot, output free_slots, input ready);
	modport sink(input valid, input status, input wqe_start_slot, input doorbell_slot,
		input epoch_bit, input msg_entry_index, input first_psn, input end_psn,
		input inline_payload, input head_slot, input free_slots, output ready);
endinterface

/* src/sqpt_divider.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sqpt_divider
	import sqpt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]  dvd_q;
	logic [SLOT_W-1:0] dsr_q;
	logic [SLOT_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W-1:0]  bit_idx;
	logic [SLOT_W:0]   rem_sh;
	logic              ge;

	// Bring down the next dividend bit and try the subtraction.
	always_comb begin
		bit_idx = cnt_q - 1'b1;
		rem_sh  = {rem_q, dvd_q[bit_idx]};
		ge      = rem_sh >= {1'b0, dsr_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				cnt_q  <= req.nbits;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand, partial remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? SLOT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[SLOT_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

/* src/send_queue_psn_tracker_core.sv */
// Top level of the send-queue tracker: sequencer, queue state and result register.
`timescale 1ns / 1ps

// One transaction is taken at a time and passes through a small sequencer that drives a
// single shared radix-2 divider, one quotient bit per cycle; the reductions of the head
// and tail modulo the queue depth and of the message pointer modulo the table size, and
// the packet count of a message, run on that unit. Every transaction first reduces the
// head and then the tail and checks the free slots; a completion or a refused post then
// emits its result. An accepted post goes on to divide the length by the MTU, to reduce
// the message pointer (skipped with a zero table size) and to advance the tail (divided
// only when it wraps) before it commits. The next request is taken once the result has
// been placed in the output register, which holds it until the sink takes it.
module send_queue_psn_tracker_core
	import sqpt_pkg::*;
#(
	parameter int SLOTS_PER_WQE = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	sqpt_req_if.sink          req,
	sqpt_rsp_if.source        rsp
);

	localparam int PROD_W = SLOT_W + $clog2(SLOTS_PER_WQE + 1);

	// Configuration registers.
	logic [SLOT_W-1:0] depth_q;
	logic [MTU_W-1:0]  mtu_q;
	logic [SLOT_W-1:0] tsize_q;
	logic [SLOT_W-1:0] ilim_q;

	// Queue state.
	logic [SLOT_W-1:0] tail_q;
	logic [SLOT_W-1:0] head_q;
	logic              epoch_q;
	logic [PSN_W-1:0]  psn_q;
	logic [SLOT_W-1:0] mptr_q;

	// Transaction under work and intermediate results.
	logic              op_q;
	logic [LEN_W-1:0]  len_q;
	logic              wr_q;
	logic [SLOT_W-1:0] cidx_q;
	logic [SLOT_W-1:0] hm_q;
	logic [SLOT_W-1:0] tm_q;
	logic [SLOT_W-1:0] new_tail_q;
	logic              new_epoch_q;
	logic [PSN_W-1:0]  new_psn_q;
	logic [SLOT_W-1:0] new_ptr_q;
	result_t           res_q;

	// Sequencer and output register.
	state_t  state_q;
	state_t  state_d;
	logic    issued_q;
	logic    out_valid_q;
	result_t out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [SLOT_W-1:0] d_eff;
	logic [SLOT_W-1:0] mtu_eff;
	logic [PROD_W-1:0] prod;
	logic [SLOT_W:0]   tail_step;
	logic              tail_wraps;
	logic [SLOT_W-1:0] free_now;
	logic [SLOT_W-1:0] free_post;
	logic [PSN_W-1:0]  pkts;
	logic              take_in;
	logic              load_out;

	// Effective operands and helper arithmetic.
	always_comb begin
		d_eff      = (depth_q == '0) ? SLOT_W'(1) : depth_q;
		mtu_eff    = (mtu_q == '0) ? SLOT_W'(1) : SLOT_W'(mtu_q);
		prod       = PROD_W'(cidx_q) * PROD_W'(SLOTS_PER_WQE);
		tail_step  = (SLOT_W + 1)'(tail_q) + (SLOT_W + 1)'(SLOTS_PER_WQE);
		tail_wraps = tail_step >= {1'b0, d_eff};
		free_now   = sqpt_free(tm_q, hm_q, d_eff);
		free_post  = sqpt_free(new_tail_q, hm_q, d_eff);
		if (len_q == '0) begin
			pkts = PSN_W'(1);
		end else begin
			pkts = div_rsp.quotient[PSN_W-1:0] + PSN_W'(div_rsp.remainder != '0);
		end
	end

	assign take_in  = req.valid && req.ready;
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	sqpt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
			mtu_q   <= MTU_RESET;
			tsize_q <= TSIZE_RESET;
			ilim_q  <= ILIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUEUE_DEPTH:    depth_q <= cfg_wdata;
				REG_PATH_MTU:       mtu_q   <= cfg_wdata[MTU_W-1:0];
				REG_MSG_TABLE_SIZE: tsize_q <= cfg_wdata;
				REG_INLINE_LIMIT:   ilim_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_HEAD_MOD;
			end
			ST_HEAD_MOD: begin
				if (div_rsp.done) state_d = ST_TAIL_MOD;
			end
			ST_TAIL_MOD: begin
				if (div_rsp.done) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (op_q == OP_COMPLETE || free_now < SLOT_W'(SLOTS_PER_WQE)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_LEN_DIV;
				end
			end
			ST_LEN_DIV: begin
				if (div_rsp.done) state_d = ST_PTR_MOD;
			end
			ST_PTR_MOD: begin
				if (tsize_q == '0 || div_rsp.done) state_d = ST_TAIL_ADV;
			end
			ST_TAIL_ADV: begin
				if (!tail_wraps || div_rsp.done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: divider requests and input ready.
	always_comb begin
		div_req       = '0;
		div_req.start = 1'b0;
		req.ready     = (state_q == ST_IDLE);
		unique case (state_q)
			ST_HEAD_MOD: begin
				div_req.start    = !issued_q;
				div_req.divisor  = d_eff;
				if (op_q == OP_COMPLETE) begin
					div_req.dividend = DIV_W'(prod);
					div_req.nbits    = CNT_W'(PROD_W);
				end else begin
					div_req.dividend = DIV_W'(head_q);
					div_req.nbits    = CNT_W'(SLOT_W);
				end
			end
			ST_TAIL_MOD: begin
				div_req.start    = !issued_q;
				div_req.divisor  = d_eff;
				div_req.dividend = DIV_W'(tail_q);
				div_req.nbits    = CNT_W'(SLOT_W);
			end
			ST_LEN_DIV: begin
				div_req.start    = !issued_q;
				div_req.divisor  = mtu_eff;
				div_req.dividend = DIV_W'(len_q);
				div_req.nbits    = CNT_W'(LEN_W);
			end
			ST_PTR_MOD: begin
				div_req.start    = !issued_q && (tsize_q != '0);
				div_req.divisor  = tsize_q;
				div_req.dividend = DIV_W'((SLOT_W + 1)'(mptr_q) + (SLOT_W + 1)'(1));
				div_req.nbits    = CNT_W'(SLOT_W + 1);
			end
			ST_TAIL_ADV: begin
				div_req.start    = !issued_q && tail_wraps;
				div_req.divisor  = d_eff;
				div_req.dividend = DIV_W'(tail_step);
				div_req.nbits    = CNT_W'(SLOT_W + 1);
			end
			default: ;
		endcase
	end

	// Control registers of the sequencer and output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_rsp.done) begin
				issued_q <= 1'b0;
			end else if (div_req.start) begin
				issued_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Queue state, committed by completions and accepted posts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q  <= '0;
			head_q  <= '0;
			epoch_q <= 1'b0;
			psn_q   <= '0;
			mptr_q  <= '0;
		end else begin
			if (state_q == ST_HEAD_MOD && div_rsp.done && op_q == OP_COMPLETE) begin
				head_q <= div_rsp.remainder;
			end
			if (state_q == ST_FINISH) begin
				tail_q  <= new_tail_q;
				epoch_q <= new_epoch_q;
				psn_q   <= new_psn_q;
				mptr_q  <= new_ptr_q;
			end
		end
	end

	// Working registers of the transaction in flight.
	always_ff @(posedge clk) begin
		if (take_in) begin
			op_q   <= req.opcode;
			len_q  <= req.msg_length;
			wr_q   <= req.is_rdma_write;
			cidx_q <= req.consumer_index;
		end
		if (state_q == ST_HEAD_MOD && div_rsp.done) begin
			hm_q <= div_rsp.remainder;
		end
		if (state_q == ST_TAIL_MOD && div_rsp.done) begin
			tm_q <= div_rsp.remainder;
		end
		if (state_q == ST_LEN_DIV && div_rsp.done) begin
			new_psn_q <= psn_q + pkts;
		end
		if (state_q == ST_PTR_MOD) begin
			if (tsize_q == '0) begin
				new_ptr_q <= mptr_q + SLOT_W'(1);
			end else if (div_rsp.done) begin
				new_ptr_q <= div_rsp.remainder;
			end
		end
		if (state_q == ST_TAIL_ADV) begin
			if (!tail_wraps) begin
				new_tail_q  <= tail_step[SLOT_W-1:0];
				new_epoch_q <= epoch_q;
			end else if (div_rsp.done) begin
				new_tail_q  <= div_rsp.remainder;
				new_epoch_q <= !epoch_q;
			end
		end
		// Result of a completion or a refused post: current state unchanged.
		if (state_q == ST_CHECK) begin
			res_q.status          <= (op_q == OP_COMPLETE) ? STAT_COMPLETE : STAT_REFUSED;
			res_q.wqe_start_slot  <= tail_q;
			res_q.doorbell_slot   <= tail_q;
			res_q.epoch_bit       <= epoch_q;
			res_q.msg_entry_index <= mptr_q;
			res_q.first_psn       <= psn_q;
			res_q.end_psn         <= psn_q;
			res_q.inline_payload  <= 1'b0;
			res_q.head_slot       <= head_q;
			res_q.free_slots      <= free_now;
		end
		// Result of an accepted post.
		if (state_q == ST_FINISH) begin
			res_q.status          <= STAT_POSTED;
			res_q.wqe_start_slot  <= tail_q;
			res_q.doorbell_slot   <= new_tail_q;
			res_q.epoch_bit       <= new_epoch_q;
			res_q.msg_entry_index <= mptr_q;
			res_q.first_psn       <= psn_q;
			res_q.end_psn         <= new_psn_q;
			res_q.inline_payload  <= wr_q && (len_q <= LEN_W'(ilim_q));
			res_q.head_slot       <= head_q;
			res_q.free_slots      <= free_post;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	// Result channel.
	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.wqe_start_slot  = out_q.wqe_start_slot;
	assign rsp.doorbell_slot   = out_q.doorbell_slot;
	assign rsp.epoch_bit       = out_q.epoch_bit;
	assign rsp.msg_entry_index = out_q.msg_entry_index;
	assign rsp.first_psn       = out_q.first_psn;
	assign rsp.end_psn         = out_q.end_psn;
	assign rsp.inline_payload  = out_q.inline_payload;
	assign rsp.head_slot       = out_q.head_slot;
	assign rsp.free_slots      = out_q.free_slots;

`ifndef SYNTHESIS
	// The divider is never started while it is still iterating.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// A divider result only arrives for a request that was issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> issued_q)
		else $error("divider result without a request");

	// Reduced head and tail lie below the depth when free slots are computed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (hm_q < d_eff) && (tm_q < d_eff))
		else $error("reduced pointer not below depth");

	// The advanced tail lies below the depth before it is committed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (new_tail_q < d_eff))
		else $error("new tail not below depth");
`endif

endmodule
